// ===== design/lcsd_pkg.sv =====
// Package for the LRU cache set: sizes, field widths, the per-cell
// operation code and the structs passed between the top level and the cells.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lcsd_pkg;

    // Set geometry
    localparam int WAYS     = 8;
    localparam int TAG_W    = 20;
    localparam int CFG_W    = 4;
    localparam int OCC_W    = 4;
    localparam int CNT_W    = $clog2(WAYS + 1);
    localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int S_DATA_W = ((TAG_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((OCC_W + 7) / 8) * 8;
    localparam int M_USER_W = 4;

    localparam logic [CFG_W-1:0] WAYS_IN_USE_RESET = CFG_W'(8);

    // Update applied to every cell once the lookup has resolved
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_HIT   = 2'd1,
        OP_FILL  = 2'd2,
        OP_EVICT = 2'd3
    } cell_op_t;

    // Lookup request broadcast to all cells
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] count;
    } cell_req_t;

    // Update command broadcast to all cells
    typedef struct packed {
        cell_op_t          op;
        logic              wr;
        logic [RANK_W-1:0] hit_rank;
        logic [RANK_W-1:0] new_rank;
    } cell_upd_t;

    // Priority chain handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [RANK_W-1:0] hit_rank;
        logic              ev_found;
        logic              ev_dirty;
    } cell_chain_t;

endpackage

`default_nettype wire

// ===== design/lru_cache_set_with_dirty.sv =====
// LRU cache set with dirty marks: top level.
// Holds the line count, the way limit register and the result register,
// and drives a row of lcsd_cell instances. Depends on lcsd_pkg, lcsd_cell.
//
// Usage:
//   s_ channel: one access per item, s_tdata[19:0] = tag, s_tuser[0] = is_write.
//   m_ channel: one result per access, m_tdata[3:0] = occupancy,
//     m_tuser[0] = hit, [1] = was_most_recent, [2] = evicted,
//     [3] = evicted_dirty.
//   cfg channel: cfg_data[3:0] = ways_in_use, always ready; write only
//     while no access is outstanding.
// The result is registered in the output register in the cycle after the
// access is taken. Throughput: one access per cycle unless the receiver stalls;
// all ways compare at once and the hit and victim choice ripple along the row
// of cells in the same cycle, so the state is up to date for the next access.
// Reset (aresetn low, synchronous) empties the set, clears the result valid flag
// and sets ways_in_use to 8. Line storage is not cleared; ways at or above
// the line count are never read.
// When the receiver stalls, the result holds and s_tready stays low until
// the result is taken; s_tready is high again in the cycle it is taken.
`timescale 1ns / 1ps
`default_nettype none

module lru_cache_set_with_dirty
    import lcsd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // access items
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // [19:0] tag, rest zero
    input  wire logic                s_tuser,  // [0] is_write
    // result items
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,  // [3:0] occupancy, rest zero
    output logic [M_USER_W-1:0]      m_tuser,  // [0] hit, [1] was_most_recent,
                                               // [2] evicted, [3] evicted_dirty
    // way limit register
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    logic [CFG_W-1:0]    ways_in_use_reg;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic                m_valid_reg, m_valid_next;
    logic [OCC_W-1:0]    occ_reg,     occ_next;
    logic [M_USER_W-1:0] flags_reg,   flags_next;

    logic                accept;
    logic [CMP_W-1:0]    limit;
    logic                is_hit;
    logic                is_mru;
    logic                do_fill;
    cell_req_t           req;
    cell_upd_t           upd;
    cell_chain_t         chain [WAYS+1];

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    // Effective way limit: zero acts as one, saturate at the way count
    always_comb begin
        if (ways_in_use_reg == '0) begin
            limit = CMP_W'(1);
        end else if (CMP_W'(ways_in_use_reg) > CMP_W'(WAYS)) begin
            limit = CMP_W'(WAYS);
        end else begin
            limit = CMP_W'(ways_in_use_reg);
        end
    end

    // Lookup request
    always_comb begin
        req.tag   = s_tdata[TAG_W-1:0];
        req.count = count_reg;
    end

    // Row of cells
    assign chain[0] = '0;

    for (genvar i = 0; i < WAYS; i++) begin : g_cell
        lcsd_cell u_cell (
            .aclk      (aclk),
            .cell_idx  (CNT_W'(i)),
            .req       (req),
            .upd       (upd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    // Decide the update once the chain has resolved
    always_comb begin
        is_hit  = chain[WAYS].found;
        is_mru  = is_hit && ((CNT_W'(chain[WAYS].hit_rank) + CNT_W'(1)) == count_reg);
        do_fill = !is_hit && (CMP_W'(count_reg) < limit);

        upd.wr       = s_tuser;
        upd.hit_rank = chain[WAYS].hit_rank;
        upd.new_rank = do_fill ? RANK_W'(count_reg) : RANK_W'(count_reg - CNT_W'(1));
        if (!accept) begin
            upd.op = OP_NONE;
        end else if (is_hit) begin
            upd.op = OP_HIT;
        end else if (do_fill) begin
            upd.op = OP_FILL;
        end else begin
            upd.op = OP_EVICT;
        end
    end

    // Count and result register
    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        occ_next     = occ_reg;
        flags_next   = flags_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            if (upd.op == OP_FILL) begin
                count_next = count_reg + CNT_W'(1);
            end
            m_valid_next  = 1'b1;
            occ_next      = OCC_W'(count_next);
            flags_next[0] = is_hit;
            flags_next[1] = is_mru;
            flags_next[2] = (upd.op == OP_EVICT);
            flags_next[3] = (upd.op == OP_EVICT) && chain[WAYS].ev_dirty;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
            ways_in_use_reg <= WAYS_IN_USE_RESET;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                ways_in_use_reg <= cfg_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        occ_reg   <= occ_next;
        flags_reg <= flags_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(occ_reg);
    assign m_tuser  = flags_reg;

endmodule

`default_nettype wire

// ===== design/lcsd_cell.sv =====
// One way of the set: tag, dirty mark and recency rank, with the local
// compare and the link in the hit / victim priority chain.
// Depends on lcsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcsd_cell
    import lcsd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic [CNT_W-1:0] cell_idx,
    input  wire cell_req_t        req,
    input  wire cell_upd_t        upd,
    input  wire cell_chain_t      chain_in,
    output cell_chain_t           chain_out
);

    logic [TAG_W-1:0]  tag_reg,   tag_next;
    logic              dirty_reg, dirty_next;
    logic [RANK_W-1:0] rank_reg,  rank_next;

    logic way_valid;
    logic match;
    logic rank_zero;
    logic sel_hit;
    logic sel_ev;

    // Lookup and chain link; the first matching way wins
    always_comb begin
        way_valid = (cell_idx < req.count);
        match     = way_valid && (tag_reg == req.tag);
        rank_zero = way_valid && (rank_reg == '0);
        sel_hit   = match && !chain_in.found;
        sel_ev    = rank_zero && !chain_in.ev_found;

        chain_out.found    = chain_in.found || match;
        chain_out.hit_rank = sel_hit ? rank_reg : chain_in.hit_rank;
        chain_out.ev_found = chain_in.ev_found || rank_zero;
        chain_out.ev_dirty = sel_ev ? dirty_reg : chain_in.ev_dirty;
    end

    // State update
    always_comb begin
        tag_next   = tag_reg;
        dirty_next = dirty_reg;
        rank_next  = rank_reg;
        case (upd.op)
            OP_HIT: begin
                if (way_valid && (rank_reg > upd.hit_rank)) begin
                    rank_next = rank_reg - RANK_W'(1);
                end
                if (sel_hit) begin
                    rank_next  = upd.new_rank;
                    dirty_next = dirty_reg | upd.wr;
                end
            end
            OP_FILL: begin
                if (cell_idx == req.count) begin
                    tag_next   = req.tag;
                    dirty_next = upd.wr;
                    rank_next  = upd.new_rank;
                end
            end
            OP_EVICT: begin
                if (way_valid && (rank_reg != '0)) begin
                    rank_next = rank_reg - RANK_W'(1);
                end
                if (sel_ev) begin
                    tag_next   = req.tag;
                    dirty_next = upd.wr;
                    rank_next  = upd.new_rank;
                end
            end
            default: begin
            end
        endcase
    end

    // Line storage, payload only
    always_ff @(posedge aclk) begin
        tag_reg   <= tag_next;
        dirty_reg <= dirty_next;
        rank_reg  <= rank_next;
    end

endmodule

`default_nettype wire

// ===== design/lcsd_checker.sv =====
// Port-level checks for the LRU cache set, bound to the top level.
// Depends on lcsd_pkg and lru_cache_set_with_dirty.
`timescale 1ns / 1ps
`default_nettype none

module lcsd_checker
    import lcsd_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [M_USER_W-1:0] m_tuser
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item present after reset");

    // A stalled result item holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    // Flags are consistent: most recent needs a hit, eviction needs a miss,
    // a dirty eviction needs an eviction
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[1] && !m_tuser[0]) && !(m_tuser[2] && m_tuser[0])
                     && !(m_tuser[3] && !m_tuser[2]))
        else $error("inconsistent result flags");

    // After any access the set holds between one and all ways
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OCC_W-1:0] != '0) && (m_tdata[OCC_W-1:0] <= OCC_W'(WAYS)))
        else $error("occupancy out of range");

endmodule

bind lru_cache_set_with_dirty lcsd_checker u_lcsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_lru_cache_set_with_dirty.sv =====
// Self-checking testbench for lru_cache_set_with_dirty: a short directed run, then random
// phases of accesses at several way limits, each result checked against an LRU predictor.
// Depends on lcsd_pkg and the lru_cache_set_with_dirty top level.
`timescale 1ns / 1ps

module tb_lru_cache_set_with_dirty;
    import lcsd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned POOL_SIZE   = 16;

    // One access item and one result item
    typedef struct {
        logic [TAG_W-1:0] tag;
        logic             wr;
    } access_t;

    typedef struct packed {
        logic             hit;
        logic             was_most_recent;
        logic             evicted;
        logic             evicted_dirty;
        logic [OCC_W-1:0] occupancy;
    } outcome_t;

    // Receiver behaviour, picked anew at random by the receiver process
    typedef enum logic [1:0] {
        RX_OPEN = 2'd0,
        RX_COIN = 2'd1,
        RX_SLOW = 2'd2
    } rx_mode_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;  // [19:0] tag, rest zero
    logic                s_tuser   = 1'b0; // [0] is_write
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // [3:0] occupancy, rest zero
    logic [M_USER_W-1:0] m_tuser;         // [0] hit, [1] was_most_recent,
                                          // [2] evicted, [3] evicted_dirty
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;

    // Predictor state: a private copy of the set
    logic [TAG_W-1:0]  set_tag   [WAYS];
    logic              set_dirty [WAYS];
    logic [RANK_W-1:0] set_rank  [WAYS];
    int unsigned       set_lines = 0;
    logic [CFG_W-1:0]  set_ways  = WAYS_IN_USE_RESET;

    access_t          pending_accesses[$];
    outcome_t         expected_outcomes[$];
    logic [TAG_W-1:0] tag_pool[POOL_SIZE];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned mode_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    bit          s_taken = 1'b0;
    bit          cfg_taken = 1'b0;

    lru_cache_set_with_dirty i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // True LRU update of the private set; returns what the block should report
    function automatic outcome_t lru_access(logic [TAG_W-1:0] tag, logic wr);
        outcome_t          res;
        cell_op_t          op;
        int unsigned       lim;
        int unsigned       w;
        logic [RANK_W-1:0] r;
        res = '0;
        op  = OP_NONE;
        w   = 0;
        lim = (set_ways == 0) ? 1 : ((set_ways > WAYS) ? WAYS : set_ways);
        for (int unsigned i = 0; i < set_lines; i++) begin
            if (op == OP_NONE && set_tag[i] == tag) begin
                op = OP_HIT;
                w  = i;
            end
        end
        if (op == OP_NONE)
            op = (set_lines < lim) ? OP_FILL : OP_EVICT;
        case (op)
            OP_HIT: begin
                r = set_rank[w];
                res.hit = 1'b1;
                res.was_most_recent = (int'(r) + 1 == set_lines);
                for (int unsigned i = 0; i < set_lines; i++)
                    if (set_rank[i] > r) set_rank[i]--;
                set_rank[w] = RANK_W'(set_lines - 1);
                if (wr) set_dirty[w] = 1'b1;
            end
            OP_FILL: begin
                set_tag[set_lines]   = tag;
                set_dirty[set_lines] = wr;
                set_rank[set_lines]  = RANK_W'(set_lines);
                set_lines++;
            end
            OP_EVICT: begin
                // victim is the way ranked least recent
                for (int i = int'(set_lines) - 1; i >= 0; i--)
                    if (set_rank[i] == '0) w = i;
                res.evicted = 1'b1;
                res.evicted_dirty = set_dirty[w];
                for (int unsigned i = 0; i < set_lines; i++)
                    if (set_rank[i] > 0) set_rank[i]--;
                set_tag[w]   = tag;
                set_dirty[w] = wr;
                set_rank[w]  = RANK_W'(set_lines - 1);
            end
            default: ;
        endcase
        res.occupancy = OCC_W'(set_lines);
        return res;
    endfunction

    // Monitor: predict on each accepted access, check each accepted result
    always @(posedge aclk) begin : monitor
        outcome_t want;
        outcome_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                set_ways  = cfg_data;
                cfg_taken = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                expected_outcomes.push_back(lru_access(s_tdata[TAG_W-1:0], s_tuser));
                s_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tuser[1], m_tuser[2], m_tuser[3], m_tdata[OCC_W-1:0]};
                if (expected_outcomes.size() == 0) begin
                    $error("result item with no access outstanding");
                    fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.was_most_recent !== want.was_most_recent) begin
                        $error("was_most_recent: expected %0d, got %0d",
                               want.was_most_recent, got.was_most_recent);
                        fail_count++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                        fail_count++;
                    end
                    if (got.evicted_dirty !== want.evicted_dirty) begin
                        $error("evicted_dirty: expected %0d, got %0d",
                               want.evicted_dirty, got.evicted_dirty);
                        fail_count++;
                    end
                    if (got.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, got.occupancy);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Driver: bursts of accesses with random gaps, item held until taken
    always @(negedge aclk) begin : driver
        access_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_taken) begin
            // still waiting for s_tready
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
            nxt = pending_accesses.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= S_DATA_W'(nxt.tag);
            s_tuser  <= nxt.wr;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            s_tvalid <= 1'b0;
        end
        s_taken = 1'b0;
    end

    // Receiver: always ready, coin toss, or mostly stalled
    always @(negedge aclk) begin : receiver
        if (mode_left == 0) begin
            mode_left = $urandom_range(16, 160);
            rx_mode = rx_mode_t'($urandom_range(0, 2));
        end else begin
            mode_left--;
        end
        case (rx_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_COIN: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic add_access(logic [TAG_W-1:0] tag, logic wr);
        access_t a;
        a.tag = tag;
        a.wr  = wr;
        pending_accesses.push_back(a);
    endtask

    // Everything sent and answered; looked at on the rising edge, where the driver's
    // queue and s_tvalid are settled
    task automatic wait_idle();
        do
            @(posedge aclk);
        while (pending_accesses.size() != 0 || s_tvalid || expected_outcomes.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_ways(logic [CFG_W-1:0] v);
        wait_idle();
        cfg_taken = 1'b0;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(negedge aclk);
        while (!cfg_taken) @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly tags from a shared pool so hits and evictions stay frequent
    task automatic queue_random(int unsigned n);
        int unsigned pool_used;
        int unsigned k;
        logic [TAG_W-1:0] t;
        pool_used = $urandom_range(1, POOL_SIZE - 2);
        for (int unsigned i = 0; i < $urandom_range(0, 6); i++)
            tag_pool[$urandom_range(0, POOL_SIZE - 1)] = TAG_W'($urandom);
        for (int unsigned i = 0; i < n; i++) begin
            k = $urandom_range(0, 19);
            if (k < 16)       t = tag_pool[$urandom_range(0, pool_used - 1)];
            else if (k == 16) t = '0;
            else if (k == 17) t = '1;
            else              t = TAG_W'($urandom);
            add_access(t, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] limits[12];
        limits = '{4'd3, 4'd4, 4'd6, 4'd7, 4'd15, 4'd4, 4'd9, 4'd0, 4'd8, 4'd1, 4'd12, 4'd5};
        for (int unsigned i = 0; i < POOL_SIZE; i++)
            tag_pool[i] = TAG_W'($urandom);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset limit, then limit of zero behaving as one
        add_access('0, 1'b0);              // fill, occupancy 1
        add_access('0, 1'b1);              // hit on most recent, now dirty
        write_ways(4'd0);
        add_access('1, 1'b0);              // full at one line: evicts dirty line
        add_access('1, 1'b1);              // hit on most recent
        write_ways(4'd1);
        add_access('0, 1'b0);              // evicts dirty line again
        write_ways(4'd2);
        add_access('1, 1'b0);              // fill, occupancy 2
        add_access('0, 1'b1);              // hit, not most recent
        add_access(20'h5A5A5, 1'b0);       // evicts clean least recent line

        // Random phases; limits above eight saturate, later small ones sit below occupancy
        foreach (limits[p]) begin
            write_ways(limits[p]);
            queue_random($urandom_range(80, 100));
        end

        wait_idle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lcsd_pkg.sv
design/lcsd_cell.sv
design/lru_cache_set_with_dirty.sv
design/lcsd_checker.sv
tb/sv/tb_lru_cache_set_with_dirty.sv
